>>> sv/cpc_pkg.sv
// Package for the pileup coverage counter: codes, constants and shared types.
// No dependencies; used by cpc_front, cpc_back and the top level.
`default_nettype none

package cpc_pkg;

	localparam int POS_W     = 40;
	localparam int CURSOR_W  = 41;
	localparam int LEN_W     = 13;
	localparam int OFFSET_W  = 12;
	localparam int OUT_W     = 16;
	localparam int CMD_W     = 2;
	localparam int OP_W      = 4;
	localparam int BASE_W    = 3;
	localparam int NUM_BASES = 6;
	localparam int NUM_FIELDS = NUM_BASES + 1;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int COUNT_BITS_DEF   = 16;

	localparam logic [POS_W-1:0] WINDOW_START_RST  = '0;
	localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = LEN_W'(4096);

	localparam logic REG_WINDOW_START  = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_CIGAR = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_e;

	localparam logic [OP_W-1:0] OP_M  = 4'd0;
	localparam logic [OP_W-1:0] OP_I  = 4'd1;
	localparam logic [OP_W-1:0] OP_D  = 4'd2;
	localparam logic [OP_W-1:0] OP_N  = 4'd3;
	localparam logic [OP_W-1:0] OP_S  = 4'd4;
	localparam logic [OP_W-1:0] OP_H  = 4'd5;
	localparam logic [OP_W-1:0] OP_P  = 4'd6;
	localparam logic [OP_W-1:0] OP_EQ = 4'd7;
	localparam logic [OP_W-1:0] OP_X  = 4'd8;

	localparam logic [BASE_W-1:0] BASE_N     = 3'd4;
	localparam logic [BASE_W-1:0] BASE_OTHER = 3'd5;

	typedef enum logic {
		JOB_COUNT = 1'b0,
		JOB_QUERY = 1'b1
	} job_kind_e;

	typedef struct packed {
		job_kind_e             kind;
		logic [BASE_W-1:0]     base;
		logic [OFFSET_W-1:0]   offset;
	} job_t;

	typedef struct packed {
		logic [OFFSET_W-1:0]                offset;
		logic [OUT_W-1:0]                   depth;
		logic [NUM_BASES-1:0][OUT_W-1:0]    counts;
	} result_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_RMW   = 2'd2
	} back_state_e;

	typedef struct packed {
		logic clearing;
		logic ram_we;
		logic ram_re;
		logic query_pop;
		logic res_push;
	} back_stat_t;

endpackage

`default_nettype wire

>>> sv/cpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/cpc_fifo.sv
// Small register FIFO, power-of-two depth.
// No dependencies.
`default_nettype none

module cpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output      logic             full,
	input  wire logic             rd_en,
	output      logic [WIDTH-1:0] rd_data,
	output      logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> sv/cpc_front.sv
// Front end: accepts commands, keeps the reference cursor, classifies ops
// against the window and issues count and query jobs. Depends on cpc_pkg.
`default_nettype none

module cpc_front #(
	parameter int WINDOW_DEPTH = cpc_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output      logic                              full,
	input  wire logic [cpc_pkg::CMD_W-1:0]         command,
	input  wire logic [cpc_pkg::POS_W-1:0]         position,
	input  wire logic [cpc_pkg::OP_W-1:0]          cigar_op,
	input  wire logic [cpc_pkg::BASE_W-1:0]        read_base,
	input  wire logic [cpc_pkg::POS_W-1:0]         window_start,
	input  wire logic [cpc_pkg::LEN_W-1:0]         window_length,
	input  wire logic                              blocked,
	input  wire logic                              job_full,
	output      logic                              job_push,
	output      cpc_pkg::job_t                     job,
	output      logic [$clog2(WINDOW_DEPTH)-1:0]   job_addr
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = cpc_pkg::CURSOR_W;
	localparam logic [CW-1:0] DEPTH_L = CW'(WINDOW_DEPTH);

	logic [CW-1:0]                 cursor_q;
	logic                          valid_s1;
	logic [cpc_pkg::CMD_W-1:0]     cmd_s1;
	logic [cpc_pkg::POS_W-1:0]     pos_s1;
	logic [cpc_pkg::OP_W-1:0]      op_s1;
	logic [cpc_pkg::BASE_W-1:0]    base_s1;
	logic [CW-1:0]                 cursor_s1;

	logic              accept;
	logic              advance;
	logic              step;
	logic [CW-1:0]     eff_len;
	logic [CW:0]       diff;
	logic              in_win;
	logic              need_count;
	logic              need_query;
	logic [cpc_pkg::BASE_W-1:0] cnt_base;

	function automatic logic [cpc_pkg::BASE_W-1:0] read_base_clip(
		input logic [cpc_pkg::BASE_W-1:0] b
	);
		return (b > cpc_pkg::BASE_OTHER) ? cpc_pkg::BASE_OTHER : b;
	endfunction

	assign accept = push && !full;

	always_comb begin
		case (cigar_op)
			cpc_pkg::OP_M, cpc_pkg::OP_EQ, cpc_pkg::OP_X,
			cpc_pkg::OP_N, cpc_pkg::OP_D: step = 1'b1;
			default:                      step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			if (command == cpc_pkg::CMD_START) begin
				cursor_q <= CW'(position);
			end else if (command == cpc_pkg::CMD_CIGAR && step) begin
				cursor_q <= cursor_q + 1'b1;
			end
		end
	end

	// classification of the staged item
	assign eff_len = (CW'(window_length) > DEPTH_L) ? DEPTH_L : CW'(window_length);
	assign diff    = {1'b0, cursor_s1} - {2'b00, window_start};
	assign in_win  = !diff[CW] && (diff[CW-1:0] < eff_len);

	always_comb begin
		need_count = 1'b0;
		cnt_base   = read_base_clip(base_s1);
		if (cmd_s1 == cpc_pkg::CMD_CIGAR) begin
			case (op_s1)
				cpc_pkg::OP_M, cpc_pkg::OP_EQ, cpc_pkg::OP_X: begin
					need_count = in_win;
				end
				cpc_pkg::OP_N: begin
					need_count = in_win;
					cnt_base   = cpc_pkg::BASE_N;
				end
				default: begin
					need_count = 1'b0;
				end
			endcase
		end
	end

	assign need_query = (cmd_s1 == cpc_pkg::CMD_QUERY) && (CW'(pos_s1) < eff_len);

	assign job_push = valid_s1 && (need_count || need_query) && !job_full;
	assign advance  = !valid_s1 || !(need_count || need_query) || !job_full;
	assign full     = blocked || !advance;

	always_comb begin
		job.kind   = need_query ? cpc_pkg::JOB_QUERY : cpc_pkg::JOB_COUNT;
		job.base   = cnt_base;
		job.offset = pos_s1[cpc_pkg::OFFSET_W-1:0];
		job_addr   = need_query ? pos_s1[AW-1:0] : diff[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			pos_s1    <= position;
			op_s1     <= cigar_op;
			base_s1   <= read_base;
			cursor_s1 <= cursor_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/cpc_back.sv
// Back end: clearing pass, read-modify-write of the tally RAM, query results.
// Depends on cpc_pkg and cpc_ram.
`default_nettype none

module cpc_back #(
	parameter int WINDOW_DEPTH = cpc_pkg::WINDOW_DEPTH_DEF,
	parameter int COUNT_BITS   = cpc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              job_valid,
	input  wire cpc_pkg::job_t                     job,
	input  wire logic [$clog2(WINDOW_DEPTH)-1:0]   job_addr,
	output      logic                              job_pop,
	input  wire logic                              res_full,
	output      logic                              res_push,
	output      cpc_pkg::result_t                  res,
	output      cpc_pkg::back_stat_t               stat
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CB = COUNT_BITS;
	localparam int RW = cpc_pkg::NUM_FIELDS * CB;

	cpc_pkg::back_state_e state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     addr_q;
	cpc_pkg::job_t     job_q;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic [RW-1:0]     ram_rdata;
	logic [RW-1:0]     row_inc;
	logic              take;

	cpc_ram #(
		.WIDTH (RW),
		.DEPTH (WINDOW_DEPTH)
	) u_tally (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (job_addr),
		.rdata (ram_rdata)
	);

	// field 0 is depth, field 1+b is base b
	always_comb begin
		logic [CB-1:0] cur;
		logic          hit;
		for (int k = 0; k < cpc_pkg::NUM_FIELDS; k++) begin
			cur = ram_rdata[k*CB +: CB];
			hit = (k == 0) || (k == int'(job_q.base) + 1);
			row_inc[k*CB +: CB] = (hit && !(&cur)) ? cur + 1'b1 : cur;
		end
	end

	always_comb begin
		res.offset = job_q.offset;
		res.depth  = cpc_pkg::OUT_W'(ram_rdata[0 +: CB]);
		for (int b = 0; b < cpc_pkg::NUM_BASES; b++) begin
			res.counts[b] = cpc_pkg::OUT_W'(ram_rdata[(b+1)*CB +: CB]);
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		job_pop   = 1'b0;
		res_push  = 1'b0;
		take      = 1'b0;
		case (state_q)
			cpc_pkg::BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(WINDOW_DEPTH - 1)) begin
					state_d = cpc_pkg::BK_IDLE;
				end
			end
			cpc_pkg::BK_IDLE: begin
				if (job_valid && (job.kind != cpc_pkg::JOB_QUERY || !res_full)) begin
					take    = 1'b1;
					job_pop = 1'b1;
					ram_re  = 1'b1;
					state_d = cpc_pkg::BK_RMW;
				end
			end
			cpc_pkg::BK_RMW: begin
				ram_we = 1'b1;
				if (job_q.kind == cpc_pkg::JOB_QUERY) begin
					res_push = 1'b1;
				end else begin
					ram_wdata = row_inc;
				end
				state_d = cpc_pkg::BK_IDLE;
			end
			default: begin
				state_d = cpc_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpc_pkg::BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cpc_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q  <= job;
			addr_q <= job_addr;
		end
	end

	always_comb begin
		stat.clearing  = (state_q == cpc_pkg::BK_CLEAR);
		stat.ram_we    = ram_we;
		stat.ram_re    = ram_re;
		stat.query_pop = take && (job.kind == cpc_pkg::JOB_QUERY);
		stat.res_push  = res_push;
	end

endmodule

`default_nettype wire

>>> sv/cigar_pileup_coverage_counter.sv
// Pileup coverage counter top level: config registers, front end, job queue,
// back end with tally RAM, result queue. Depends on cpc_pkg and all cpc_ modules.
// Start and non-counting cigar items: one per cycle while full is low. Counting ops and
// queries: the back end takes a new job only after the read-modify-write of the last
// one in the single tally RAM. A query passes the job queue and the result queue.
// Reset: async; a clearing pass zeroes every RAM row while full stays high.
`default_nettype none

module cigar_pileup_coverage_counter #(
	parameter int WINDOW_DEPTH = cpc_pkg::WINDOW_DEPTH_DEF,
	parameter int COUNT_BITS   = cpc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output      logic                          full,
	input  wire logic [cpc_pkg::CMD_W-1:0]     command,
	input  wire logic [cpc_pkg::POS_W-1:0]     position,
	input  wire logic [cpc_pkg::OP_W-1:0]      cigar_op,
	input  wire logic [cpc_pkg::BASE_W-1:0]    read_base,
	output      logic                          empty,
	input  wire logic                          pop,
	output      logic [cpc_pkg::OFFSET_W-1:0]  offset,
	output      logic [cpc_pkg::OUT_W-1:0]     depth,
	output      logic [cpc_pkg::OUT_W-1:0]     count_a,
	output      logic [cpc_pkg::OUT_W-1:0]     count_c,
	output      logic [cpc_pkg::OUT_W-1:0]     count_g,
	output      logic [cpc_pkg::OUT_W-1:0]     count_t,
	output      logic [cpc_pkg::OUT_W-1:0]     count_n,
	output      logic [cpc_pkg::OUT_W-1:0]     count_other,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [cpc_pkg::POS_W-1:0]     cfg_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int JW = $bits(cpc_pkg::job_t) + AW;
	localparam int QW = $bits(cpc_pkg::result_t);

	logic [cpc_pkg::POS_W-1:0]  window_start_q;
	logic [cpc_pkg::LEN_W-1:0]  window_length_q;

	logic                 job_push;
	cpc_pkg::job_t        job_in;
	logic [AW-1:0]        job_addr_in;
	logic                 job_full;
	logic                 job_empty;
	logic                 job_pop;
	logic [JW-1:0]        job_word;
	cpc_pkg::job_t        job_out;
	logic [AW-1:0]        job_addr_out;

	logic                 res_push;
	logic                 res_full;
	cpc_pkg::result_t     res_in;
	logic [QW-1:0]        res_word;
	cpc_pkg::result_t     res_out;
	cpc_pkg::back_stat_t  stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q  <= cpc_pkg::WINDOW_START_RST;
			window_length_q <= cpc_pkg::WINDOW_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpc_pkg::REG_WINDOW_START:  window_start_q  <= cfg_data;
				cpc_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[cpc_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cpc_front #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.position      (position),
		.cigar_op      (cigar_op),
		.read_base     (read_base),
		.window_start  (window_start_q),
		.window_length (window_length_q),
		.blocked       (stat.clearing),
		.job_full      (job_full),
		.job_push      (job_push),
		.job           (job_in),
		.job_addr      (job_addr_in)
	);

	cpc_fifo #(
		.WIDTH (JW),
		.DEPTH (2)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data ({job_in, job_addr_in}),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_word),
		.empty   (job_empty)
	);

	assign job_out      = cpc_pkg::job_t'(job_word[JW-1:AW]);
	assign job_addr_out = job_word[AW-1:0];

	cpc_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_addr  (job_addr_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.stat      (stat)
	);

	cpc_fifo #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_word),
		.empty   (empty)
	);

	assign res_out     = cpc_pkg::result_t'(res_word);
	assign offset      = res_out.offset;
	assign depth       = res_out.depth;
	assign count_a     = res_out.counts[0];
	assign count_c     = res_out.counts[1];
	assign count_g     = res_out.counts[2];
	assign count_t     = res_out.counts[3];
	assign count_n     = res_out.counts[4];
	assign count_other = res_out.counts[5];

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> full)
		else $error("item taken during clearing pass");

	a_ram_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.ram_we && stat.ram_re))
		else $error("tally RAM read and written in one cycle");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_push |-> !res_full)
		else $error("result queue overflow");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		stat.query_pop |=> stat.res_push)
		else $error("query did not produce a result");

endmodule

`default_nettype wire
